// ===== sv/pxcmp_pkg.sv =====
// Shared types, constants and helpers for the pixel compare block.
// No dependencies; imported by pxcmp_pixel and the top level.
package pxcmp_pkg;

    // Field widths
    localparam int PIX_W       = 8;
    localparam int COUNT_W     = 25;
    localparam int COORD_W     = 12;
    localparam int WIDTH_REG_W = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;

    // Parameter defaults
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    // Register reset values
    localparam logic [PIX_W-1:0]       TOLERANCE_RESET   = 8'd0;
    localparam logic [WIDTH_REG_W-1:0] IMAGE_WIDTH_RESET = 13'd640;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_TOLERANCE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH = 2'd1;

    // Diff colour constants
    localparam logic [PIX_W+1:0] RED_BASE = 10'd128;
    localparam logic [PIX_W-1:0] PIX_MAX  = 8'd255;

    // Divide by three as multiply by 683 / 2^11, exact for sums up to 765
    localparam logic [19:0] RECIP_3 = 20'd683;

    typedef struct packed {
        logic [PIX_W-1:0] golden_red;
        logic [PIX_W-1:0] golden_green;
        logic [PIX_W-1:0] golden_blue;
        logic [PIX_W-1:0] current_red;
        logic [PIX_W-1:0] current_green;
        logic [PIX_W-1:0] current_blue;
        logic             last_pixel;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0]   diff_red;
        logic [PIX_W-1:0]   diff_green;
        logic [PIX_W-1:0]   diff_blue;
        logic               pixel_differs;
        logic [COUNT_W-1:0] differing_count;
        logic [PIX_W-1:0]   largest_delta;
        logic [COORD_W-1:0] first_diff_x;
        logic [COORD_W-1:0] first_diff_y;
        logic               any_difference;
        logic               frame_done;
    } t_pix_out;

    // Per-pixel evaluation handed from pxcmp_pixel to the statistics logic
    typedef struct packed {
        logic [PIX_W-1:0] delta;
        logic             differs;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_pix_eval;

    function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    // floor(floor(sum/3)/4) of the three channels
    function automatic logic [PIX_W-1:0] gray_level(input logic [PIX_W-1:0] r,
                                                    input logic [PIX_W-1:0] g,
                                                    input logic [PIX_W-1:0] b);
        logic [19:0] sum;
        logic [19:0] prod;
        sum  = 20'(r) + 20'(g) + 20'(b);
        prod = sum * RECIP_3;
        // bits above 11 give sum/3, two more give the /4
        gray_level = {1'b0, prod[19:13]};
    endfunction

endpackage

// ===== sv/pxcmp_pixel.sv =====
// Per-pixel evaluation: worst channel delta, tolerance test and diff colour.
// Depends on pxcmp_pkg.
module pxcmp_pixel (
    input  pxcmp_pkg::t_pix_in         i_pix,
    input  logic [pxcmp_pkg::PIX_W-1:0] i_tolerance,
    output pxcmp_pkg::t_pix_eval       o_eval
);
    import pxcmp_pkg::*;

    logic [PIX_W-1:0] w_dr, w_dg, w_db;
    logic [PIX_W-1:0] w_max_rg, w_worst;
    logic [PIX_W+1:0] w_red_raw;
    logic [PIX_W-1:0] w_gray;
    logic             w_differs;

    // channel deltas and their maximum
    assign w_dr     = abs_diff(i_pix.golden_red,   i_pix.current_red);
    assign w_dg     = abs_diff(i_pix.golden_green, i_pix.current_green);
    assign w_db     = abs_diff(i_pix.golden_blue,  i_pix.current_blue);
    assign w_max_rg = (w_dg > w_dr) ? w_dg : w_dr;
    assign w_worst  = (w_db > w_max_rg) ? w_db : w_max_rg;

    assign w_differs = w_worst > i_tolerance;

    // red intensity, saturating
    assign w_red_raw = RED_BASE + {1'b0, w_worst, 1'b0};
    assign w_gray    = gray_level(i_pix.current_red, i_pix.current_green,
                                  i_pix.current_blue);

    // diff colour select
    always_comb begin
        o_eval.delta   = w_worst;
        o_eval.differs = w_differs;
        if (w_differs) begin
            o_eval.red   = (w_red_raw > {2'b00, PIX_MAX}) ? PIX_MAX : w_red_raw[PIX_W-1:0];
            o_eval.green = '0;
            o_eval.blue  = '0;
        end else begin
            o_eval.red   = w_gray;
            o_eval.green = w_gray;
            o_eval.blue  = w_gray;
        end
    end

endmodule

// ===== sv/pixel_compare_with_tolerance_top.sv =====
// Top level of the pixel compare block: handshake, config and frame statistics.
// Depends on pxcmp_pkg and pxcmp_pixel.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+---------------------
//  pixel in | in        | i_in_valid / o_in_ready    | i_in  (t_pix_in)
//  diff out | out       | o_out_valid / i_out_ready  | o_out (t_pix_out)
//  config   | in        | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// One pixel pair per clock while the result is not held downstream; a pair passes the input register,
// then the result register, with the statistics updated as the result is loaded.
// While a result waits downstream the input register takes one more request,
// then o_in_ready stays low until the waiting result is taken.
// Synchronous active-low reset clears both valids, the frame statistics and
// sets tolerance to 0 and image width to 640.
module pixel_compare_with_tolerance_top #(
    parameter int MAX_WIDTH  = pxcmp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = pxcmp_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  pxcmp_pkg::t_pix_in                i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output pxcmp_pkg::t_pix_out               o_out,
    input  logic                              i_cfg_we,
    input  logic [pxcmp_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [pxcmp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import pxcmp_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = (CW + 1 > WIDTH_REG_W) ? CW + 1 : WIDTH_REG_W;
    localparam int XW = (CW > COORD_W) ? CW : COORD_W;
    localparam int YW = (RW > COORD_W) ? RW : COORD_W;

    // configuration
    logic [PIX_W-1:0]       r_tolerance;
    logic [WIDTH_REG_W-1:0] r_image_width;

    // pipeline
    logic      r_in_valid;
    t_pix_in   r_in;
    logic      r_out_valid;
    t_pix_out  r_out;
    logic      w_adv;
    logic      w_fire;
    t_pix_eval w_eval;

    // frame state
    logic [CW-1:0]      r_col,       n_col;
    logic [RW-1:0]      r_row,       n_row;
    logic [COUNT_W-1:0] r_diff_total, n_diff_total;
    logic [PIX_W-1:0]   r_peak,      n_peak;
    logic               r_seen,      n_seen;
    logic [CW-1:0]      r_first_col, n_first_col;
    logic [RW-1:0]      r_first_row, n_first_row;

    logic [WW-1:0] w_width_eff;
    logic [WW-1:0] w_next_col;
    logic [XW-1:0] w_fx;
    logic [YW-1:0] w_fy;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance   <= TOLERANCE_RESET;
            r_image_width <= IMAGE_WIDTH_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_TOLERANCE) begin
                r_tolerance <= i_cfg_data[PIX_W-1:0];
            end
            if (i_cfg_index == CFG_IMAGE_WIDTH) begin
                r_image_width <= i_cfg_data[WIDTH_REG_W-1:0];
            end
        end
    end

    // handshake
    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_fire     = w_adv && r_in_valid;
    assign o_in_ready = !r_in_valid || w_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
    end

    // per-pixel evaluation
    pxcmp_pixel u_pixel (
        .i_pix       (r_in),
        .i_tolerance (r_tolerance),
        .o_eval      (w_eval)
    );

    // effective row width: zero acts as one, clamp to MAX_WIDTH
    always_comb begin
        w_width_eff = WW'(r_image_width);
        if (r_image_width == '0) begin
            w_width_eff = WW'(1);
        end
        if (w_width_eff > WW'(MAX_WIDTH)) begin
            w_width_eff = WW'(MAX_WIDTH);
        end
    end

    assign w_next_col = WW'(r_col) + WW'(1);

    // statistics after this pixel
    always_comb begin
        n_peak       = (w_eval.delta > r_peak) ? w_eval.delta : r_peak;
        n_diff_total = r_diff_total;
        n_seen       = r_seen;
        n_first_col  = r_first_col;
        n_first_row  = r_first_row;
        if (w_eval.differs) begin
            if (r_diff_total != {COUNT_W{1'b1}}) begin
                n_diff_total = r_diff_total + COUNT_W'(1);
            end
            if (!r_seen) begin
                n_seen      = 1'b1;
                n_first_col = r_col;
                n_first_row = r_row;
            end
        end
    end

    // raster position after this pixel
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_next_col >= w_width_eff) begin
            n_col = '0;
            if (r_row != RW'(MAX_HEIGHT - 1)) begin
                n_row = r_row + RW'(1);
            end
        end else begin
            n_col = w_next_col[CW-1:0];
        end
    end

    // frame state update; last pixel clears for the next frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_diff_total <= '0;
            r_peak       <= '0;
            r_seen       <= 1'b0;
            r_first_col  <= '0;
            r_first_row  <= '0;
        end else if (w_fire) begin
            if (r_in.last_pixel) begin
                r_col        <= '0;
                r_row        <= '0;
                r_diff_total <= '0;
                r_peak       <= '0;
                r_seen       <= 1'b0;
                r_first_col  <= '0;
                r_first_row  <= '0;
            end else begin
                r_col        <= n_col;
                r_row        <= n_row;
                r_diff_total <= n_diff_total;
                r_peak       <= n_peak;
                r_seen       <= n_seen;
                r_first_col  <= n_first_col;
                r_first_row  <= n_first_row;
            end
        end
    end

    assign w_fx = XW'(n_first_col);
    assign w_fy = YW'(n_first_row);

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out.diff_red        <= w_eval.red;
            r_out.diff_green      <= w_eval.green;
            r_out.diff_blue       <= w_eval.blue;
            r_out.pixel_differs   <= w_eval.differs;
            r_out.differing_count <= n_diff_total;
            r_out.largest_delta   <= n_peak;
            r_out.first_diff_x    <= w_fx[COORD_W-1:0];
            r_out.first_diff_y    <= w_fy[COORD_W-1:0];
            r_out.any_difference  <= n_seen;
            r_out.frame_done      <= r_in.last_pixel;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // checks
    a_count_matches_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out.differing_count != '0) == o_out.any_difference))
        else $error("differing count and any_difference disagree");

    a_differs_implies_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.pixel_differs) |-> o_out.any_difference)
        else $error("differing pixel without any_difference");

    a_diff_colour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.pixel_differs) |->
            (o_out.diff_green == '0 && o_out.diff_blue == '0))
        else $error("differing pixel is not pure red");

    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in.last_pixel) |=>
            (r_col == '0 && r_row == '0 && r_diff_total == '0 && !r_seen))
        else $error("statistics not cleared after last pixel");

endmodule

// ===== tb/sv/pixel_compare_with_tolerance_top_test.sv =====
// Self-checking test of the pixel compare block: a frame statistics tracker
// predicts every diff pixel; random pixel streams run under varied idling.
// Depends on pxcmp_pkg and pixel_compare_with_tolerance_top.
module pixel_compare_with_tolerance_top_test;
    import pxcmp_pkg::*;

    localparam int unsigned COUNT_LIMIT = (1 << COUNT_W) - 1;
    localparam int          IDLE_LIMIT  = 5000;
    localparam int          HOLD_CYCLES = 64;
    localparam int          LATENCY     = 4;

    // Indexes past the register list, written to show they change nothing
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

    // Tracks frame statistics and holds the diff pixels still to arrive
    class frame_diff_tracker;
        logic [PIX_W-1:0]       tolerance   = TOLERANCE_RESET;
        logic [WIDTH_REG_W-1:0] image_width = IMAGE_WIDTH_RESET;
        int unsigned column_count, row_count, diff_total, first_column, first_row;
        logic [PIX_W-1:0] peak_delta      = '0;
        logic             seen_difference = 1'b0;
        t_pix_out         expected_diffs[$];
        int               errors;

        function void restart_frame();
            column_count    = 0;
            row_count       = 0;
            diff_total      = 0;
            peak_delta      = '0;
            seen_difference = 1'b0;
            first_column    = 0;
            first_row       = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] index,
                                   logic [CFG_DATA_W-1:0] data);
            if (index == CFG_TOLERANCE) begin
                tolerance = data[PIX_W-1:0];
            end else if (index == CFG_IMAGE_WIDTH) begin
                image_width = data[WIDTH_REG_W-1:0];
            end
        endfunction

        function logic [PIX_W-1:0] channel_gap(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
            return (a > b) ? a - b : b - a;
        endfunction

        function int pending();
            return expected_diffs.size();
        endfunction

        // Work out the diff pixel for one accepted request, then step the counters
        function void note_pixel(t_pix_in px);
            logic [PIX_W-1:0] gap_r, gap_g, gap_b, worst;
            logic [9:0]       red, sum;
            int unsigned      span;
            t_pix_out         res;
            gap_r = channel_gap(px.golden_red, px.current_red);
            gap_g = channel_gap(px.golden_green, px.current_green);
            gap_b = channel_gap(px.golden_blue, px.current_blue);
            worst = gap_r;
            if (gap_g > worst) worst = gap_g;
            if (gap_b > worst) worst = gap_b;
            if (worst > peak_delta) peak_delta = worst;

            res = '0;
            res.pixel_differs = worst > tolerance;
            if (res.pixel_differs) begin
                if (diff_total < COUNT_LIMIT) diff_total++;
                if (!seen_difference) begin
                    seen_difference = 1'b1;
                    first_column    = column_count;
                    first_row       = row_count;
                end
                red = 10'd128 + {1'b0, worst, 1'b0};
                res.diff_red = (red > 10'd255) ? 8'd255 : red[PIX_W-1:0];
            end else begin
                // gray from the captured pixel only
                sum = 10'(px.current_red) + 10'(px.current_green) + 10'(px.current_blue);
                res.diff_red   = 8'((sum / 3) / 4);
                res.diff_green = res.diff_red;
                res.diff_blue  = res.diff_red;
            end
            res.differing_count = COUNT_W'(diff_total);
            res.largest_delta   = peak_delta;
            res.first_diff_x    = COORD_W'(first_column);
            res.first_diff_y    = COORD_W'(first_row);
            res.any_difference  = seen_difference;
            res.frame_done      = px.last_pixel;
            expected_diffs.push_back(res);

            if (px.last_pixel) begin
                restart_frame();
            end else begin
                span = image_width;
                if (span == 0) span = 1;
                if (span > DEF_MAX_WIDTH) span = DEF_MAX_WIDTH;
                if (column_count + 1 >= span) begin
                    column_count = 0;
                    if (row_count + 1 < DEF_MAX_HEIGHT) row_count++;
                end else begin
                    column_count++;
                end
            end
        endfunction

        function void report_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_diff(t_pix_out got);
            t_pix_out want;
            if (expected_diffs.size() == 0) begin
                $display("%0t: diff result with none pending, expected none actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = expected_diffs.pop_front();
            report_field("diff_red", want.diff_red, got.diff_red);
            report_field("diff_green", want.diff_green, got.diff_green);
            report_field("diff_blue", want.diff_blue, got.diff_blue);
            report_field("pixel_differs", want.pixel_differs, got.pixel_differs);
            report_field("differing_count", want.differing_count, got.differing_count);
            report_field("largest_delta", want.largest_delta, got.largest_delta);
            report_field("first_diff_x", want.first_diff_x, got.first_diff_x);
            report_field("first_diff_y", want.first_diff_y, got.first_diff_y);
            report_field("any_difference", want.any_difference, got.any_difference);
            report_field("frame_done", want.frame_done, got.frame_done);
        endfunction
    endclass

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_ready;
    t_pix_in                i_in        = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    t_pix_out               o_out;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = CFG_TOLERANCE;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    frame_diff_tracker tracker = new();
    int idle_cycles     = 0;
    int sender_idle_pct = 0;
    int stall_pct       = 0;
    bit hold_request    = 1'b0;
    int frame_left      = 0;

    pixel_compare_with_tolerance_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Handshake monitor: note requests, check results, count quiet cycles
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) tracker.note_pixel(i_in);
        if (i_rst_n && o_out_valid && i_out_ready) tracker.check_diff(o_out);
        if (i_rst_n && ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog
    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Offer one request and hold it until accepted
    task automatic offer_pixel(input t_pix_in px);
        i_in_valid <= 1'b1;
        i_in       <= px;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Random sender gaps, roughly sender_idle_pct of cycles
    task automatic pace_sender();
        if ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    // Stop sending, wait for every pending diff pixel, then let the pipe settle
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        tracker.set_register(index, data);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_pix_in pixel_pair(input logic [7:0] gr, gg, gb, cr, cg, cb,
                                           input logic lst);
        return '{gr, gg, gb, cr, cg, cb, lst};
    endfunction

    // Channel value near the golden one, so deltas straddle the tolerance
    function automatic logic [PIX_W-1:0] near_value(input logic [PIX_W-1:0] base,
                                                    input int tol);
        int v;
        v = int'(base) + int'($urandom_range(0, 2 * tol + 4)) - tol - 2;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    function automatic t_pix_in random_pixel(input logic lst);
        t_pix_in px;
        int      pick;
        px.golden_red   = 8'($urandom);
        px.golden_green = 8'($urandom);
        px.golden_blue  = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 25) begin
            px.current_red   = 8'($urandom);
            px.current_green = 8'($urandom);
            px.current_blue  = 8'($urandom);
        end else if (pick < 40) begin
            px.current_red   = px.golden_red;
            px.current_green = px.golden_green;
            px.current_blue  = px.golden_blue;
        end else begin
            px.current_red   = near_value(px.golden_red, tracker.tolerance);
            px.current_green = near_value(px.golden_green, tracker.tolerance);
            px.current_blue  = near_value(px.golden_blue, tracker.tolerance);
        end
        px.last_pixel = lst;
        return px;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_tolerance();
        case ($urandom_range(3))
            0:       return '0;
            1:       return 13'd255;
            2:       return 13'($urandom_range(1, 30));
            default: return 13'($urandom);    // upper bits dropped by the register
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_width();
        case ($urandom_range(5))
            0:       return '0;
            1:       return 13'd1;
            2:       return 13'($urandom_range(2, 9));
            3:       return 13'd4096;
            4:       return 13'h1FFF;
            default: return 13'($urandom);
        endcase
    endfunction

    // Random frames of 1 to 24 pixels, the odd stray end-of-frame mark mixed in
    task automatic run_frames(input int count, input int snd_pct, input int rcv_pct,
                              input bit settle);
        logic lst;
        sender_idle_pct = snd_pct;
        stall_pct       = rcv_pct;
        write_register(CFG_TOLERANCE, pick_tolerance());
        write_register(CFG_IMAGE_WIDTH, pick_width());
        for (int i = 0; i < count; i++) begin
            if (frame_left == 0) frame_left = $urandom_range(1, 24);
            frame_left--;
            lst = (frame_left == 0) || ($urandom_range(99) < 3);
            if (lst) frame_left = 0;
            offer_pixel(random_pixel(lst));
            if (settle && i == count / 2) begin
                wait_for_results();
            end else begin
                pace_sender();
            end
        end
        wait_for_results();
    endtask

    // One long frame of matching pixels with a single difference at diff_at
    task automatic run_long_frame(input logic [CFG_DATA_W-1:0] width, input int length,
                                  input int diff_at);
        t_pix_in px;
        write_register(CFG_TOLERANCE, 13'd254);
        write_register(CFG_IMAGE_WIDTH, width);
        for (int i = 0; i < length; i++) begin
            px.golden_red   = 8'($urandom);
            px.golden_green = 8'($urandom);
            px.golden_blue  = 8'($urandom);
            px.current_red   = px.golden_red;
            px.current_green = px.golden_green;
            px.current_blue  = px.golden_blue;
            if (i == diff_at) begin
                px.golden_red  = 8'd0;
                px.current_red = 8'd255;
            end
            px.last_pixel = (i == length - 1);
            offer_pixel(px);
        end
        wait_for_results();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, tolerance 0 and width 640
        offer_pixel(pixel_pair(0, 0, 0, 0, 0, 0, 0));
        offer_pixel(pixel_pair(255, 255, 255, 255, 255, 255, 0));
        offer_pixel(pixel_pair(10, 20, 30, 11, 20, 30, 0));
        offer_pixel(pixel_pair(100, 100, 100, 100, 163, 100, 0));
        offer_pixel(pixel_pair(100, 100, 100, 100, 100, 36, 0));
        offer_pixel(pixel_pair(0, 0, 0, 255, 255, 255, 0));
        offer_pixel(pixel_pair(255, 255, 255, 0, 0, 0, 1));
        wait_for_results();

        // Tolerance boundary, with masked upper data bits; zero width
        write_register(CFG_TOLERANCE, 13'h1F0A);
        write_register(CFG_IMAGE_WIDTH, 13'd0);
        offer_pixel(pixel_pair(50, 50, 50, 60, 40, 50, 0));
        offer_pixel(pixel_pair(50, 50, 50, 61, 50, 50, 0));
        offer_pixel(pixel_pair(7, 8, 9, 7, 8, 9, 1));
        wait_for_results();

        // Full tolerance, oversized width, writes to unused indexes
        write_register(CFG_TOLERANCE, 13'h1FFF);
        write_register(CFG_IMAGE_WIDTH, 13'h1FFF);
        write_register(CFG_SPARE_A, 13'd0);
        write_register(CFG_SPARE_B, 13'h1FFF);
        offer_pixel(pixel_pair(0, 0, 0, 255, 255, 255, 0));
        offer_pixel(pixel_pair(255, 0, 255, 0, 255, 0, 1));
        wait_for_results();

        // Width of one, then three
        write_register(CFG_TOLERANCE, 13'd0);
        write_register(CFG_IMAGE_WIDTH, 13'd1);
        offer_pixel(pixel_pair(1, 2, 3, 1, 2, 3, 0));
        offer_pixel(pixel_pair(4, 5, 6, 4, 5, 6, 0));
        offer_pixel(pixel_pair(4, 5, 6, 4, 5, 9, 0));
        offer_pixel(pixel_pair(9, 9, 9, 9, 9, 9, 1));
        wait_for_results();
        write_register(CFG_IMAGE_WIDTH, 13'd3);
        offer_pixel(pixel_pair(20, 20, 20, 20, 20, 20, 0));
        offer_pixel(pixel_pair(30, 30, 30, 30, 30, 30, 0));
        offer_pixel(pixel_pair(40, 40, 40, 40, 40, 40, 0));
        offer_pixel(pixel_pair(50, 50, 50, 50, 50, 50, 0));
        offer_pixel(pixel_pair(60, 60, 60, 60, 80, 60, 0));
        offer_pixel(pixel_pair(70, 70, 70, 71, 70, 70, 1));
        offer_pixel(pixel_pair(1, 2, 3, 4, 5, 6, 1));
        wait_for_results();

        // Random frames under each idling pattern, settings changed between phases
        for (int pass = 0; pass < 2; pass++) begin
            run_frames(40, 0, 0, pass == 0);
            run_frames(40, 70, 0, 1'b0);
            run_frames(40, 0, 70, pass == 1);
            run_frames(40, 6, 6, 1'b0);
        end

        // Long receiver hold-off while requests keep coming, so the input stalls
        sender_idle_pct = 0;
        stall_pct       = 0;
        hold_request    = 1'b1;
        for (int i = 0; i < 40; i++) begin
            if (frame_left == 0) frame_left = $urandom_range(1, 24);
            frame_left--;
            offer_pixel(random_pixel(frame_left == 0));
        end
        wait_for_results();

        // Close any open frame, then an oversized width and a zero width
        if (frame_left != 0) begin
            offer_pixel(random_pixel(1'b1));
            frame_left = 0;
            wait_for_results();
        end
        run_long_frame(13'h1FFF, 20, 15);
        run_long_frame(13'd0, 20, 18);

        wait_for_results();
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
